[rtl/pbvf_pkg.sv]
// Package for the pitch bend and vibrato period generator: codes, states and the period table.
package pbvf_pkg;

  // Channel count and channel codes
  localparam int unsigned NumCh = 4;
  localparam logic [1:0] ChPulse1 = 2'd0;
  localparam logic [1:0] ChPulse2 = 2'd1;
  localparam logic [1:0] ChWave   = 2'd2;
  localparam logic [1:0] ChNoise  = 2'd3;

  // Item kinds
  localparam logic KindBend = 1'b0;
  localparam logic KindTick = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CfgSpeed0 = 3'd0;
  localparam logic [2:0] CfgSpeed1 = 3'd1;
  localparam logic [2:0] CfgSpeed2 = 3'd2;
  localparam logic [2:0] CfgSpeed3 = 3'd3;
  localparam logic [2:0] CfgDepth0 = 3'd4;
  localparam logic [2:0] CfgDepth1 = 3'd5;
  localparam logic [2:0] CfgDepth2 = 3'd6;
  localparam logic [2:0] CfgDepth3 = 3'd7;

  // Wheel arithmetic
  localparam logic [7:0] WheelUpBase = 8'h7F;
  localparam logic [7:0] WheelMid    = 8'd128;

  // Shift-and-add multiply: seven multiplier bits, last step index
  localparam logic [2:0] MulLastStep = 3'd6;

  // Notes that carry a period
  localparam logic [6:0] NoteLow  = 7'd36;
  localparam logic [6:0] NoteHigh = 7'd107;

  localparam logic [15:0] PeriodTab [0:71] = '{
    16'd44,   16'd156,  16'd262,  16'd363,  16'd457,  16'd547,
    16'd631,  16'd710,  16'd786,  16'd854,  16'd923,  16'd986,
    16'd1046, 16'd1102, 16'd1155, 16'd1205, 16'd1253, 16'd1297,
    16'd1339, 16'd1379, 16'd1417, 16'd1452, 16'd1486, 16'd1517,
    16'd1546, 16'd1575, 16'd1602, 16'd1627, 16'd1650, 16'd1673,
    16'd1694, 16'd1714, 16'd1732, 16'd1750, 16'd1767, 16'd1783,
    16'd1798, 16'd1812, 16'd1825, 16'd1837, 16'd1849, 16'd1860,
    16'd1871, 16'd1881, 16'd1890, 16'd1899, 16'd1907, 16'd1915,
    16'd1923, 16'd1930, 16'd1936, 16'd1943, 16'd1949, 16'd1954,
    16'd1959, 16'd1964, 16'd1969, 16'd1974, 16'd1978, 16'd1982,
    16'd1985, 16'd1988, 16'd1992, 16'd1995, 16'd1998, 16'd2001,
    16'd2004, 16'd2006, 16'd2009, 16'd2011, 16'd2013, 16'd2015
  };

  // Period of a note; notes outside the table span read as zero
  function automatic logic [15:0] period_lookup(logic [6:0] note);
    logic [6:0] idx;
    idx = note - NoteLow;
    if (note >= NoteLow && note <= NoteHigh) begin
      return PeriodTab[idx];
    end
    return 16'd0;
  endfunction

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StBendDiff,
    StBendMul,
    StBendFin,
    StBendEmit,
    StTickVisit,
    StTickEmit
  } pbvf_state_e;

endpackage

[rtl/pitch_bend_vibrato_freq.sv]
// Top level: four-channel pitch bend and triangle vibrato period generator.
//
// Input channel (in_valid_i / in_stall_o) takes one item at a time. A bend item
// (kind 0) looks up the note and range periods, then a shared 16-bit adder
// forms the difference, runs a 7-step shift-and-add multiply and applies the
// scaled step: the single result then goes to the output register.
// A tick item (kind 1) visits the four channels in order, where the same adder
// forms base plus vibrato position, and enters an emit step for each due
// channel to hand its result over; a tick holds the input stalled until all
// four channels are visited, which takes longer if the receiver stalls.
// The stall drops once the sequencer is back in idle after each item, and the
// adder is shared across all steps.
// Results go through an output register (out_valid_o / out_stall_i); the block
// takes a new item while a finished result still waits there, and blocks only
// when a further result is ready and the register is still held.
// Configuration is a plain write port: speeds at indexes 0..3, depths 4..7.
// Reset clears all channel state and the output, speeds go to 1, depths to 0.
module pitch_bend_vibrato_freq
  import pbvf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_kind_i,
  input  logic [1:0]  in_channel_i,
  input  logic [6:0]  in_note_i,
  input  logic [7:0]  in_wheel_i,
  input  logic [6:0]  in_range_high_note_i,
  input  logic [6:0]  in_range_low_note_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_target_o,
  output logic [15:0] out_period_o,
  output logic        out_last_o
);

  // Configuration and channel state
  logic [7:0]  speed_q [NumCh];
  logic [7:0]  depth_q [NumCh];
  logic [15:0] base_q  [NumCh];
  logic [7:0]  pos_q   [NumCh];
  logic        rise_q  [NumCh];
  logic [7:0]  timer_q [NumCh];

  // Sequencer
  pbvf_state_e state_q, state_d;
  logic [1:0]  ch_q;
  logic [1:0]  vis_q;
  logic [3:0]  due_q;
  logic [2:0]  cnt_q;

  // Bend datapath
  logic        up_q;
  logic [15:0] f_q, r_q;
  logic [6:0]  frac_q;
  logic [15:0] mcand_q, acc_q, res_q;

  // Output register
  logic        out_valid_q;
  logic [1:0]  out_target_q;
  logic [15:0] out_value_q;
  logic        out_last_q;

  logic        in_accept, out_free;
  logic [3:0]  due_now;
  logic [7:0]  d_up, d_dn;
  logic [15:0] add_a, add_b, add_y;
  logic        add_sub;
  logic [7:0]  cur_pos, cur_dep, pos_new;
  logic        cur_rise, rise_new;
  logic        higher_due;
  logic        out_load;
  logic [1:0]  out_target_d;
  logic [15:0] out_value_d;
  logic        out_last_d;
  logic        vis_adv;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  // Channels due at the start of a tick
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      due_now[c] = (depth_q[c] != 8'd0) && (timer_q[c] == speed_q[c]);
    end
  end

  // Wheel distance from centre, up and down
  assign d_up = in_wheel_i - WheelUpBase;
  assign d_dn = WheelMid - in_wheel_i;

  // Triangle step of the channel being visited
  assign cur_pos  = pos_q[vis_q];
  assign cur_dep  = depth_q[vis_q];
  assign cur_rise = rise_q[vis_q];
  always_comb begin
    if (cur_rise && cur_pos < cur_dep) begin
      pos_new  = cur_pos + 8'd1;
      rise_new = 1'b1;
    end else if (cur_pos != 8'd0) begin
      pos_new  = cur_pos - 8'd1;
      rise_new = 1'b0;
    end else begin
      pos_new  = cur_pos;
      rise_new = 1'b1;
    end
  end

  // Any due channel after the one being visited
  always_comb begin
    higher_due = 1'b0;
    for (int c = 0; c < NumCh; c++) begin
      if (c > int'(vis_q)) begin
        higher_due = higher_due | due_q[c];
      end
    end
  end

  // Shared adder: operand selection
  always_comb begin
    add_a   = 16'd0;
    add_b   = 16'd0;
    add_sub = 1'b0;
    unique case (state_q)
      StBendDiff: begin
        add_a   = up_q ? r_q : f_q;
        add_b   = up_q ? f_q : r_q;
        add_sub = 1'b1;
      end
      StBendMul: begin
        add_a = acc_q;
        add_b = mcand_q;
      end
      StBendFin: begin
        add_a   = f_q;
        add_b   = {6'd0, acc_q[15:6]};
        add_sub = !up_q;
      end
      StTickVisit: begin
        add_a = base_q[vis_q];
        add_b = {8'd0, pos_new};
      end
      default: begin
        add_a = 16'd0;
      end
    endcase
  end

  assign add_y = add_sub ? (add_a - add_b) : (add_a + add_b);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = (in_kind_i == KindBend) ? StBendDiff : StTickVisit;
        end
      end
      StBendDiff: state_d = StBendMul;
      StBendMul: begin
        if (cnt_q == MulLastStep) begin
          state_d = StBendFin;
        end
      end
      StBendFin: state_d = StBendEmit;
      StBendEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      StTickVisit: begin
        if (due_q[vis_q]) begin
          state_d = StTickEmit;
        end else if (vis_q == ChNoise) begin
          state_d = StIdle;
        end
      end
      StTickEmit: begin
        if (out_free) begin
          state_d = (vis_q == ChNoise) ? StIdle : StTickVisit;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs: result loading and channel advance
  always_comb begin
    out_load     = 1'b0;
    out_target_d = ch_q;
    out_value_d  = res_q;
    out_last_d   = 1'b1;
    vis_adv      = 1'b0;
    unique case (state_q)
      StBendEmit: begin
        out_load     = out_free;
        out_target_d = (ch_q == ChNoise) ? ChWave : ch_q;
      end
      StTickVisit: begin
        vis_adv = !due_q[vis_q];
      end
      StTickEmit: begin
        out_load     = out_free;
        out_target_d = vis_q;
        out_last_d   = !higher_due;
        vis_adv      = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Control state, configuration and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vis_q       <= 2'd0;
      due_q       <= 4'd0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NumCh; c++) begin
        speed_q[c] <= 8'd1;
        depth_q[c] <= 8'd0;
        base_q[c]  <= 16'd0;
        pos_q[c]   <= 8'd0;
        rise_q[c]  <= 1'b0;
        timer_q[c] <= 8'd0;
      end
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_index_i) inside
          CfgSpeed0, CfgSpeed1, CfgSpeed2, CfgSpeed3: speed_q[cfg_index_i[1:0]] <= cfg_data_i;
          CfgDepth0, CfgDepth1, CfgDepth2, CfgDepth3: depth_q[cfg_index_i[1:0]] <= cfg_data_i;
          default: ;
        endcase
      end

      // start of a tick
      if (in_accept && in_kind_i == KindTick) begin
        due_q <= due_now;
        vis_q <= 2'd0;
      end

      // multiply step counter
      if (state_q == StBendDiff) begin
        cnt_q <= 3'd0;
      end else if (state_q == StBendMul) begin
        cnt_q <= cnt_q + 3'd1;
      end

      // bend result stored as the channel base
      if (state_q == StBendFin) begin
        base_q[ch_q] <= add_y;
      end

      // vibrato visit: timer and triangle update
      if (state_q == StTickVisit && cur_dep != 8'd0) begin
        if (due_q[vis_q]) begin
          timer_q[vis_q] <= 8'd1;
          pos_q[vis_q]   <= pos_new;
          rise_q[vis_q]  <= rise_new;
        end else begin
          timer_q[vis_q] <= timer_q[vis_q] + 8'd1;
        end
      end

      if (vis_adv) begin
        vis_q <= vis_q + 2'd1;
      end

      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept && in_kind_i == KindBend) begin
      ch_q   <= in_channel_i;
      up_q   <= in_wheel_i[7];
      f_q    <= period_lookup(in_note_i);
      r_q    <= period_lookup(in_wheel_i[7] ? in_range_high_note_i : in_range_low_note_i);
      frac_q <= in_wheel_i[7] ? d_up[7:1] : d_dn[7:1];
    end
    unique case (state_q)
      StBendDiff: begin
        mcand_q <= add_y;
        acc_q   <= 16'd0;
      end
      StBendMul: begin
        if (frac_q[0]) begin
          acc_q <= add_y;
        end
        mcand_q <= {mcand_q[14:0], 1'b0};
        frac_q  <= {1'b0, frac_q[6:1]};
      end
      StBendFin: res_q <= add_y;
      StTickVisit: res_q <= (vis_q == ChNoise) ? {8'd0, add_y[7:0]} : add_y;
      default: ;
    endcase
    if (out_load) begin
      out_target_q <= out_target_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_target_o = out_target_q;
  assign out_period_o = out_value_q;
  assign out_last_o   = out_last_q;

`ifndef NO_ASSERTIONS
  // A new result never overwrites one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  // An accepted bend item starts the difference step
  a_bend_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_kind_i == KindBend) |=> (state_q == StBendDiff))
    else $error("bend item did not start the sequencer");

  // Vibrato results come only from channels found due at tick start
  a_emit_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTickEmit) |-> due_q[vis_q])
    else $error("vibrato result for a channel that was not due");
`endif

endmodule
